// ===== hw/rtl/poc_pkg.sv =====
// Shared types and constants for the partition offset calculator.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
`default_nettype none

package poc_pkg;

	// Field widths fixed by the port list.
	localparam int FIELD_W = 48;
	localparam int NODE_W  = 4;
	localparam int CFG_W   = 5;

	// Node count after reset.
	localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 5'd1;

	// One input word as it sits in the input register.
	typedef struct packed {
		logic [NODE_W-1:0]  assigned_node;
		logic [FIELD_W-1:0] global_count;
		logic [FIELD_W-1:0] local_count;
		logic [FIELD_W-1:0] scan_sum;
		logic               first_partition;
		logic               last_partition;
	} item_t;

	// One result word as it sits in the output register.
	typedef struct packed {
		logic [FIELD_W-1:0] base_offset;
		logic [FIELD_W-1:0] relative_offset;
		logic [FIELD_W-1:0] absolute_offset;
		logic [FIELD_W-1:0] local_offset;
		logic [FIELD_W-1:0] local_total;
		logic               last_result;
		logic               error_flag;
	} result_t;

	// Write-back to the running sums produced for one word.
	typedef struct packed {
		logic node_wr_en;
		logic node_ok;
	} sum_ctrl_t;

endpackage : poc_pkg

`default_nettype wire

// ===== hw/rtl/poc_offset_unit.sv =====
// Combinational offset arithmetic for one partition word.
// Uses poc_pkg for the word and result types; the running sums live in the top level.
`default_nettype none

module poc_offset_unit #(
	parameter int COUNT_BITS = 48,
	parameter int MAX_NODES  = 16
) (
	input  poc_pkg::item_t                 item,
	input  logic [poc_pkg::CFG_W-1:0]      node_count,
	input  logic [COUNT_BITS-1:0]          node_sum_rd,
	input  logic [COUNT_BITS-1:0]          local_sum_rd,
	output poc_pkg::result_t               result,
	output poc_pkg::sum_ctrl_t             ctrl,
	output logic [COUNT_BITS-1:0]          node_sum_wr,
	output logic [COUNT_BITS-1:0]          local_sum_wr
);

	// Working width that holds both an input field and a running sum.
	localparam int WIDE_W = (COUNT_BITS > poc_pkg::FIELD_W) ? COUNT_BITS : poc_pkg::FIELD_W;
	localparam logic [WIDE_W-1:0] CMAX_WIDE = {WIDE_W{1'b1}} >> (WIDE_W - COUNT_BITS);
	localparam logic [8:0] MAX_NODES_V = 9'(MAX_NODES);

	// Clamp an input field to the sum width; the top bit flags a clamp.
	function automatic logic [COUNT_BITS:0] clamp_in(input logic [poc_pkg::FIELD_W-1:0] v);
		logic [WIDE_W-1:0] ext;
		ext = WIDE_W'(v);
		if (ext > CMAX_WIDE) begin
			clamp_in = {1'b1, {COUNT_BITS{1'b1}}};
		end else begin
			clamp_in = {1'b0, ext[COUNT_BITS-1:0]};
		end
	endfunction

	// Saturating add; the top bit flags a saturation.
	function automatic logic [COUNT_BITS:0] sat_add(input logic [COUNT_BITS-1:0] a,
			input logic [COUNT_BITS-1:0] b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[COUNT_BITS]) begin
			sat_add = {1'b1, {COUNT_BITS{1'b1}}};
		end else begin
			sat_add = s;
		end
	endfunction

	// Bring a sum back to the port width.
	function automatic logic [poc_pkg::FIELD_W-1:0] to_field(input logic [COUNT_BITS-1:0] x);
		logic [WIDE_W-1:0] ext;
		ext = WIDE_W'(x);
		to_field = ext[poc_pkg::FIELD_W-1:0];
	endfunction

	logic [COUNT_BITS:0]   gcnt_c, lcnt_c, scan_c;
	logic [COUNT_BITS:0]   node_add, abs_add, loc_add;
	logic [COUNT_BITS-1:0] base, rel, loc, total;
	logic                  node_ok, scan_ok;

	always_comb begin
		gcnt_c = clamp_in(item.global_count);
		lcnt_c = clamp_in(item.local_count);
		scan_c = clamp_in(item.scan_sum);

		// The node must be enabled and have a running sum.
		node_ok = ({1'b0, item.assigned_node} < node_count) &&
			({5'b0, item.assigned_node} < MAX_NODES_V);

		// A first word sees every running sum as zero.
		base = (node_ok && !item.first_partition) ? node_sum_rd : '0;
		loc  = item.first_partition ? '0 : local_sum_rd;

		node_add = sat_add(base, gcnt_c[COUNT_BITS-1:0]);

		scan_ok = scan_c[COUNT_BITS-1:0] >= lcnt_c[COUNT_BITS-1:0];
		rel     = scan_ok ? (scan_c[COUNT_BITS-1:0] - lcnt_c[COUNT_BITS-1:0]) : '0;

		abs_add = sat_add(base, rel);
		loc_add = sat_add(loc, lcnt_c[COUNT_BITS-1:0]);
		total   = item.last_partition ? loc_add[COUNT_BITS-1:0] : '0;

		node_sum_wr  = node_add[COUNT_BITS-1:0];
		local_sum_wr = loc_add[COUNT_BITS-1:0];

		ctrl.node_ok    = node_ok;
		ctrl.node_wr_en = node_ok;

		result.base_offset     = to_field(base);
		result.relative_offset = to_field(rel);
		result.absolute_offset = to_field(abs_add[COUNT_BITS-1:0]);
		result.local_offset    = to_field(loc);
		result.local_total     = to_field(total);
		result.last_result     = item.last_partition;
		result.error_flag      = gcnt_c[COUNT_BITS] | lcnt_c[COUNT_BITS] | scan_c[COUNT_BITS] |
			!node_ok | (node_ok & node_add[COUNT_BITS]) | !scan_ok |
			abs_add[COUNT_BITS] | loc_add[COUNT_BITS];
	end

endmodule : poc_offset_unit

`default_nettype wire

// ===== hw/rtl/partition_offset_calculator_top.sv =====
// Top level of the partition offset calculator: handshakes, running sums, result register.
// Depends on poc_pkg and poc_offset_unit.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | sink      | in_valid / in_stall  | assigned_node, counts, scan, first, last
//   out     | source    | out_valid / out_stall| offsets, local_total, last, error
//   cfg     | sink      | cfg_we               | cfg_wdata (node count, 5 bits)
//
// A word goes from input to result through the input register, then the result register.
// One word per cycle is sustained unless the output stalls; the running sums are updated
// as a word leaves the input register, so the next word reads them in the following cycle.
// Reset clears all running sums and sets the node count to one.
// A stall on the output holds the result register and then the input register.
`default_nettype none

module partition_offset_calculator_top #(
	parameter int MAX_NODES  = 16,
	parameter int COUNT_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_we,
	input  logic [poc_pkg::CFG_W-1:0]       cfg_wdata,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [poc_pkg::NODE_W-1:0]      assigned_node,
	input  logic [poc_pkg::FIELD_W-1:0]     global_count,
	input  logic [poc_pkg::FIELD_W-1:0]     local_count,
	input  logic [poc_pkg::FIELD_W-1:0]     scan_sum,
	input  logic                            first_partition,
	input  logic                            last_partition,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [poc_pkg::FIELD_W-1:0]     base_offset,
	output logic [poc_pkg::FIELD_W-1:0]     relative_offset,
	output logic [poc_pkg::FIELD_W-1:0]     absolute_offset,
	output logic [poc_pkg::FIELD_W-1:0]     local_offset,
	output logic [poc_pkg::FIELD_W-1:0]     local_total,
	output logic                            last_result,
	output logic                            error_flag
);

	// Only nodes addressable by the node field need a running sum.
	localparam int SUM_DEPTH = (MAX_NODES < 16) ? MAX_NODES : 16;
	localparam int IDX_W     = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

	logic [poc_pkg::CFG_W-1:0] node_count_q;
	poc_pkg::item_t            item_s1;
	logic                      valid_s1;
	poc_pkg::result_t          res_q;
	logic                      out_valid_q;
	logic                      advance;

	logic [COUNT_BITS-1:0]     node_sums_q [SUM_DEPTH];
	logic [COUNT_BITS-1:0]     local_sum_q;
	logic [IDX_W-1:0]          node_idx;
	logic [COUNT_BITS-1:0]     node_rd;
	logic [COUNT_BITS-1:0]     node_wr;
	logic [COUNT_BITS-1:0]     local_wr;
	poc_pkg::result_t          res_c;
	poc_pkg::sum_ctrl_t        ctrl;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= poc_pkg::NODE_COUNT_RESET;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Handshake: the input register moves on whenever the result register is free.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.assigned_node   <= assigned_node;
			item_s1.global_count    <= global_count;
			item_s1.local_count     <= local_count;
			item_s1.scan_sum        <= scan_sum;
			item_s1.first_partition <= first_partition;
			item_s1.last_partition  <= last_partition;
		end
	end

	// Read port of the node sums.
	always_comb begin
		node_idx = item_s1.assigned_node[IDX_W-1:0];
		node_rd  = (int'(node_idx) < SUM_DEPTH) ? node_sums_q[node_idx] : '0;
	end

	poc_offset_unit #(
		.COUNT_BITS (COUNT_BITS),
		.MAX_NODES  (MAX_NODES)
	) u_offset (
		.item         (item_s1),
		.node_count   (node_count_q),
		.node_sum_rd  (node_rd),
		.local_sum_rd (local_sum_q),
		.result       (res_c),
		.ctrl         (ctrl),
		.node_sum_wr  (node_wr),
		.local_sum_wr (local_wr)
	);

	// Running sums: a first word clears everything, then its own node is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SUM_DEPTH; i++) begin
				node_sums_q[i] <= '0;
			end
			local_sum_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < SUM_DEPTH; i++) begin
				if (ctrl.node_wr_en && (node_idx == IDX_W'(i))) begin
					node_sums_q[i] <= node_wr;
				end else if (item_s1.first_partition) begin
					node_sums_q[i] <= '0;
				end
			end
			local_sum_q <= local_wr;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	// Output ports.
	assign out_valid       = out_valid_q;
	assign base_offset     = res_q.base_offset;
	assign relative_offset = res_q.relative_offset;
	assign absolute_offset = res_q.absolute_offset;
	assign local_offset    = res_q.local_offset;
	assign local_total     = res_q.local_total;
	assign last_result     = res_q.last_result;
	assign error_flag      = res_q.error_flag;

`ifndef SYNTHESIS
	// The input side only stalls while a word waits in the input register.
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// A node outside the enabled range always yields an error result.
	a_bad_node_error: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !ctrl.node_ok |=> out_valid && error_flag && (base_offset == '0))
		else $error("bad node did not raise the error flag");

	// A first word starts the local prefix at zero.
	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.first_partition |=> out_valid && (local_offset == '0))
		else $error("first word did not clear the local sum");

	// The local total is only reported on the last word.
	a_total_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> (local_total == '0))
		else $error("local total reported on a word that is not last");
`endif

endmodule : partition_offset_calculator_top

`default_nettype wire

// ===== test/poc_offset_checker.sv =====
// Checker for the partition offset calculator: watches the config, input and result channels.
// Predicts every result word from its own copy of the running sums and compares field by field.
// Depends on poc_pkg for the word types and field widths.
module poc_offset_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [poc_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [poc_pkg::NODE_W-1:0]  assigned_node,
	input  logic [poc_pkg::FIELD_W-1:0] global_count,
	input  logic [poc_pkg::FIELD_W-1:0] local_count,
	input  logic [poc_pkg::FIELD_W-1:0] scan_sum,
	input  logic                        first_partition,
	input  logic                        last_partition,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [poc_pkg::FIELD_W-1:0] base_offset,
	input  logic [poc_pkg::FIELD_W-1:0] relative_offset,
	input  logic [poc_pkg::FIELD_W-1:0] absolute_offset,
	input  logic [poc_pkg::FIELD_W-1:0] local_offset,
	input  logic [poc_pkg::FIELD_W-1:0] local_total,
	input  logic                        last_result,
	input  logic                        error_flag,
	output int                          fail_count,
	output int                          pending,
	output int                          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import poc_pkg::*;

	localparam int NODES = 16;
	localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

	// Model state: per-node sums of global counts, sum of local counts, node limit.
	logic [FIELD_W-1:0] node_sums [NODES];
	logic [FIELD_W-1:0] local_sum;
	logic [CFG_W-1:0]   node_limit;

	// Expected result words, oldest first.
	result_t expected_offsets [$];
	result_t want;
	result_t seen;
	item_t   word_in;

	// Saturating add at the count width; saturation raises the error.
	function automatic logic [FIELD_W-1:0] sat_sum(input logic [FIELD_W-1:0] a,
			input logic [FIELD_W-1:0] b, inout logic err);
		logic [FIELD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[FIELD_W]) begin
			err = 1'b1;
			return COUNT_MAX;
		end
		return s[FIELD_W-1:0];
	endfunction

	// Works out the offsets of one partition and advances the running sums.
	function automatic result_t compute_offsets(input item_t w);
		result_t r;
		logic err;
		logic [FIELD_W-1:0] base;
		logic [FIELD_W-1:0] rel;
		err = 1'b0;
		base = '0;
		rel = '0;
		if (w.first_partition) begin
			foreach (node_sums[i]) node_sums[i] = '0;
			local_sum = '0;
		end
		// A node outside the configured count leaves every node sum untouched.
		if ({1'b0, w.assigned_node} < node_limit) begin
			base = node_sums[w.assigned_node];
			node_sums[w.assigned_node] = sat_sum(base, w.global_count, err);
		end else begin
			err = 1'b1;
		end
		if (w.scan_sum >= w.local_count) begin
			rel = w.scan_sum - w.local_count;
		end else begin
			err = 1'b1;
		end
		r.base_offset     = base;
		r.relative_offset = rel;
		r.absolute_offset = sat_sum(base, rel, err);
		r.local_offset    = local_sum;
		local_sum         = sat_sum(local_sum, w.local_count, err);
		r.local_total     = w.last_partition ? local_sum : '0;
		r.last_result     = w.last_partition;
		r.error_flag      = err;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [FIELD_W-1:0] exp_v,
			input logic [FIELD_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		checked = 0;
	end

	// Sample all channels at the clock edge; results are checked before new words are queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (node_sums[i]) node_sums[i] = '0;
			local_sum = '0;
			node_limit = NODE_COUNT_RESET;
			expected_offsets.delete();
			pending = 0;
		end else begin
			if (cfg_we) node_limit = cfg_wdata;

			if (out_valid && !out_stall) begin
				seen.base_offset     = base_offset;
				seen.relative_offset = relative_offset;
				seen.absolute_offset = absolute_offset;
				seen.local_offset    = local_offset;
				seen.local_total     = local_total;
				seen.last_result     = last_result;
				seen.error_flag      = error_flag;
				if (expected_offsets.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got %h", $time, seen);
					fail_count++;
				end else begin
					want = expected_offsets.pop_front();
					compare_field("base_offset", want.base_offset, seen.base_offset);
					compare_field("relative_offset", want.relative_offset,
						seen.relative_offset);
					compare_field("absolute_offset", want.absolute_offset,
						seen.absolute_offset);
					compare_field("local_offset", want.local_offset, seen.local_offset);
					compare_field("local_total", want.local_total, seen.local_total);
					compare_field("last_result", want.last_result, seen.last_result);
					compare_field("error_flag", want.error_flag, seen.error_flag);
					checked++;
				end
			end

			if (in_valid && !in_stall) begin
				word_in.assigned_node   = assigned_node;
				word_in.global_count    = global_count;
				word_in.local_count     = local_count;
				word_in.scan_sum        = scan_sum;
				word_in.first_partition = first_partition;
				word_in.last_partition  = last_partition;
				expected_offsets.push_back(compute_offsets(word_in));
			end

			pending = expected_offsets.size();
		end
	end

endmodule

// ===== test/partition_offset_calculator_top_test.sv =====
// Testbench top for the partition offset calculator: clock, reset, stimulus and verdict.
// Depends on poc_pkg, partition_offset_calculator_top and poc_offset_checker.
module partition_offset_calculator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import poc_pkg::*;

	localparam logic [FIELD_W-1:0] COUNT_MAX = '1;
	localparam int IDLE_LIMIT = 1000;
	localparam int SEGMENT_WORDS = 340;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [NODE_W-1:0]    assigned_node;
	logic [FIELD_W-1:0]   global_count;
	logic [FIELD_W-1:0]   local_count;
	logic [FIELD_W-1:0]   scan_sum;
	logic                 first_partition;
	logic                 last_partition;
	logic                 out_valid;
	logic                 out_stall;
	logic [FIELD_W-1:0]   base_offset;
	logic [FIELD_W-1:0]   relative_offset;
	logic [FIELD_W-1:0]   absolute_offset;
	logic [FIELD_W-1:0]   local_offset;
	logic [FIELD_W-1:0]   local_total;
	logic                 last_result;
	logic                 error_flag;

	int fail_count;
	int pending;
	int checked;
	int words_sent = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cur_nodes = 1;

	partition_offset_calculator_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.assigned_node   (assigned_node),
		.global_count    (global_count),
		.local_count     (local_count),
		.scan_sum        (scan_sum),
		.first_partition (first_partition),
		.last_partition  (last_partition),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.base_offset     (base_offset),
		.relative_offset (relative_offset),
		.absolute_offset (absolute_offset),
		.local_offset    (local_offset),
		.local_total     (local_total),
		.last_result     (last_result),
		.error_flag      (error_flag)
	);

	poc_offset_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.assigned_node   (assigned_node),
		.global_count    (global_count),
		.local_count     (local_count),
		.scan_sum        (scan_sum),
		.first_partition (first_partition),
		.last_partition  (last_partition),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.base_offset     (base_offset),
		.relative_offset (relative_offset),
		.absolute_offset (absolute_offset),
		.local_offset    (local_offset),
		.local_total     (local_total),
		.last_result     (last_result),
		.error_flag      (error_flag),
		.fail_count      (fail_count),
		.pending         (pending),
		.checked         (checked)
	);

	always #10 clk = ~clk;

	// The receiver stalls at random with the current profile.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Watchdog: too many cycles in a row without any accepted word ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
			$display("partition_offset_calculator_top verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [FIELD_W-1:0] rand48();
		logic [31:0] hi;
		logic [31:0] lo;
		hi = $urandom;
		lo = $urandom;
		return {hi[15:0], lo};
	endfunction

	function automatic item_t partition(input logic [NODE_W-1:0] node,
			input logic [FIELD_W-1:0] g, input logic [FIELD_W-1:0] l,
			input logic [FIELD_W-1:0] s, input logic f, input logic last);
		item_t w;
		w.assigned_node   = node;
		w.global_count    = g;
		w.local_count     = l;
		w.scan_sum        = s;
		w.first_partition = f;
		w.last_partition  = last;
		return w;
	endfunction

	// One partition of a histogram; noisy words have every field random.
	function automatic item_t make_partition(input int idx, input int len, input bit noisy);
		item_t w;
		int span;
		int sel;
		if (noisy) begin
			w.assigned_node   = NODE_W'($urandom_range(0, 15));
			w.global_count    = rand48();
			w.local_count     = rand48();
			w.scan_sum        = rand48();
			w.first_partition = 1'($urandom_range(0, 1));
			w.last_partition  = 1'($urandom_range(0, 1));
			return w;
		end
		span = (cur_nodes > 16) ? 16 : cur_nodes;
		if (span == 0 || $urandom_range(0, 19) == 0) begin
			w.assigned_node = NODE_W'($urandom_range(0, 15));
		end else begin
			w.assigned_node = NODE_W'($urandom_range(0, span - 1));
		end
		// Mostly small counts so the sums stay clear of saturation.
		sel = $urandom_range(0, 99);
		if (sel < 80) begin
			w.global_count = FIELD_W'($urandom_range(0, 100000));
			w.local_count  = FIELD_W'($urandom_range(0, 5000));
		end else if (sel < 95) begin
			w.global_count = rand48() >> 8;
			w.local_count  = rand48() >> 10;
		end else begin
			w.global_count = rand48() | 48'hF000_0000_0000;
			w.local_count  = rand48() | 48'hF000_0000_0000;
		end
		if ($urandom_range(0, 19) == 0) begin
			w.scan_sum = (w.local_count == '0) ? '0 : w.local_count - 48'd1;
		end else begin
			w.scan_sum = w.local_count + FIELD_W'($urandom_range(0, 20000));
		end
		w.first_partition = (idx == 0);
		w.last_partition  = (idx == len - 1);
		return w;
	endfunction

	// Offers one word, with random gaps before it, and waits until it is taken.
	task automatic send_word(input item_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		assigned_node   <= w.assigned_node;
		global_count    <= w.global_count;
		local_count     <= w.local_count;
		scan_sum        <= w.scan_sum;
		first_partition <= w.first_partition;
		last_partition  <= w.last_partition;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	// Holds the sender off until every expected result word has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_node_count(input logic [CFG_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		cur_nodes = int'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Streams whole histograms, with a tenth of them pure noise.
	task automatic run_histograms(input int count, input int pause_at);
		int done;
		int len;
		bit noisy;
		done = 0;
		while (done < count) begin
			len = $urandom_range(1, 40);
			noisy = ($urandom_range(0, 9) == 0);
			for (int idx = 0; idx < len; idx++) begin
				send_word(make_partition(idx, len, noisy));
				done++;
				if (done == pause_at) drain_results();
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		in_valid        = 1'b0;
		assigned_node   = '0;
		global_count    = '0;
		local_count     = '0;
		scan_sum        = '0;
		first_partition = 1'b0;
		last_partition  = 1'b0;
		out_stall       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 28;
		recv_stall_pct = 49;

		// Directed part, first with the reset node count of one.
		send_word(partition(4'd0, 48'd5, 48'd3, 48'd7, 1'b1, 1'b0));
		send_word(partition(4'd1, 48'd4, 48'd2, 48'd2, 1'b0, 1'b0));
		send_word(partition(4'd0, 48'd0, 48'd0, 48'd0, 1'b0, 1'b1));

		// All sixteen nodes: saturation of every sum and a scan below the count.
		write_node_count(5'd16);
		send_word(partition(4'd15, COUNT_MAX, 48'd0, COUNT_MAX, 1'b1, 1'b0));
		send_word(partition(4'd15, 48'd1, 48'd1, 48'd1, 1'b0, 1'b0));
		send_word(partition(4'd3, 48'd10, 48'd9, 48'd4, 1'b0, 1'b0));
		send_word(partition(4'd3, 48'd7, COUNT_MAX, COUNT_MAX, 1'b0, 1'b0));
		send_word(partition(4'd3, 48'd2, 48'd0, COUNT_MAX, 1'b0, 1'b0));
		send_word(partition(4'd0, 48'd0, 48'd0, 48'd0, 1'b0, 1'b1));
		send_word(partition(4'd7, 48'd100, 48'd50, 48'd50, 1'b1, 1'b0));
		send_word(partition(4'd7, 48'd1, 48'd1, 48'd2, 1'b1, 1'b1));
		send_word(partition(4'd15, 48'h8000_0000_0000, 48'h8000_0000_0000, COUNT_MAX,
			1'b0, 1'b1));

		// No nodes in use: every node is out of range.
		write_node_count(5'd0);
		send_word(partition(4'd0, 48'd1, 48'd1, 48'd1, 1'b1, 1'b1));

		// Largest register value with alternating bit patterns.
		write_node_count(5'd31);
		send_word(partition(4'd15, 48'd3, 48'd2, 48'd5, 1'b1, 1'b1));
		send_word(partition(4'd0, 48'h5555_5555_5555, 48'h2AAA_AAAA_AAAA,
			48'hAAAA_AAAA_AAAA, 1'b0, 1'b0));

		// Random part: six segments, two per stall profile, each with its own node count.
		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0: write_node_count(5'd16);
				1: write_node_count(CFG_W'($urandom_range(2, 15)));
				2: write_node_count(5'd1);
				3: write_node_count(5'd31);
				4: write_node_count(5'd16);
				default: write_node_count(CFG_W'($urandom_range(1, 16)));
			endcase
			case (seg / 2)
				0: begin
					send_idle_pct  = 28;
					recv_stall_pct = 49;
				end
				1: begin
					send_idle_pct  = 49;
					recv_stall_pct = 28;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			run_histograms(SEGMENT_WORDS, (seg == 0) ? 170 : -1);
		end

		drain_results();
		repeat (10) @(posedge clk);

		$display("Summary: %0d partition words sent, %0d result words checked.",
			words_sent, checked);
		$display("Node counts 0, 1, 16, 31 and random; three sender and receiver stall profiles.");
		if (fail_count == 0 && pending == 0) begin
			$display("partition_offset_calculator_top verification clean");
		end else begin
			$display("partition_offset_calculator_top verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/poc_pkg.sv
hw/rtl/poc_offset_unit.sv
hw/rtl/partition_offset_calculator_top.sv
test/poc_offset_checker.sv
test/partition_offset_calculator_top_test.sv
